>>> sv/sat_assignment_trail_top_defines.svh
// ----------------------------------------------------------------------------
// sat_assignment_trail_top_defines.svh
// Assertion macros shared by the assignment trail RTL.
// ----------------------------------------------------------------------------
`ifndef SAT_ASSIGNMENT_TRAIL_TOP_DEFINES_SVH
`define SAT_ASSIGNMENT_TRAIL_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define SATT_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define SATT_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/sat_at_pkg.sv
// ----------------------------------------------------------------------------
// sat_at_pkg
// Types, sizes and codes of the SAT assignment trail.
// ----------------------------------------------------------------------------
package sat_at_pkg;

    // Field widths
    localparam int CMD_W   = 3;
    localparam int VAR_W   = 6;
    localparam int COUNT_W = 7;
    localparam int LVL_W   = 6;
    localparam int VALUE_W = 2;
    localparam int STAT_W  = 2;

    // Sizes
    localparam logic [COUNT_W-1:0] NUM_VARS   = 7'd64;
    localparam logic [COUNT_W-1:0] MAX_LEVELS = 7'd64;

    // Commands
    localparam logic [CMD_W-1:0] CMD_ASSIGN    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_NEW_LEVEL = 3'd1;
    localparam logic [CMD_W-1:0] CMD_BACKTRACK = 3'd2;
    localparam logic [CMD_W-1:0] CMD_QUERY     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_LIST      = 3'd4;

    // Literal values
    localparam logic [VALUE_W-1:0] VAL_UNDEF = 2'd0;
    localparam logic [VALUE_W-1:0] VAL_FALSE = 2'd1;
    localparam logic [VALUE_W-1:0] VAL_TRUE  = 2'd2;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_BAD_VAR   = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD_LEVEL = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [VAR_W-1:0]   var_index;
        logic               positive;
        logic [COUNT_W-1:0] level;
    } in_item_t;

    typedef struct packed {
        logic [VALUE_W-1:0] lit_value;
        logic [VAR_W-1:0]   trail_var;
        logic               trail_positive;
        logic               entry_valid;
        logic [COUNT_W-1:0] current_level;
        logic [COUNT_W-1:0] trail_count;
        logic [STAT_W-1:0]  status;
        logic               last;
    } out_item_t;

endpackage

>>> sv/sat_assignment_trail_top.sv
// ----------------------------------------------------------------------------
// sat_assignment_trail_top
// Assignment table, literal trail and decision-level stack of a CDCL solver.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake          Payload
//  in        in   in_valid/in_ready  in_data  (sat_at_pkg::in_item_t)
//  out       out  out_valid/out_ready out_data (sat_at_pkg::out_item_t)
//
//  Assign, new level, bad or unused commands answer at once; a query reads
//  the polarity memory first. Backtrack reads the level start, then walks the
//  trail down; list level reads start and end, then one memory read per entry.
//  Reset clears both counters and all variable valid bits at once; no sweep.
//  A stalled output holds the block in its result state; a new command is
//  taken while the last result still waits in the output register.
//
module sat_assignment_trail_top (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  sat_at_pkg::in_item_t in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output sat_at_pkg::out_item_t out_data
);
    import sat_at_pkg::*;

`include "sat_assignment_trail_top_defines.svh"

    // Sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_QRY  = 4'd1;
    localparam logic [3:0] S_BTLS = 4'd2;
    localparam logic [3:0] S_BTW  = 4'd3;
    localparam logic [3:0] S_LA   = 4'd4;
    localparam logic [3:0] S_LB   = 4'd5;
    localparam logic [3:0] S_LRD  = 4'd6;
    localparam logic [3:0] S_LOUT = 4'd7;
    localparam logic [3:0] S_RESP = 4'd8;

    // Regions of the shared trail/level memory
    localparam logic REGION_TRAIL = 1'b0;
    localparam logic REGION_LEVEL = 1'b1;
    localparam int   MA_W = LVL_W + 1;
    localparam int   MA_D = 2 ** MA_W;
    localparam int   NV_D = 2 ** VAR_W;

    // Memories: trail entries and level starts; variable polarity
    logic [COUNT_W-1:0] tl_mem [MA_D];
    logic               pol_mem [NV_D];

    logic [3:0]         state_reg, state_next;
    logic [COUNT_W-1:0] dl_reg, dl_next;
    logic [COUNT_W-1:0] tl_reg, tl_next;
    logic [NV_D-1:0]    vvalid_reg, vvalid_next;
    logic               rd_pend_reg, rd_pend_next;
    logic               more_reg, more_next;
    logic               out_valid_reg, out_valid_next;
    out_item_t          out_data_reg, out_data_next;
    out_item_t          pend_reg, pend_next;
    in_item_t           req_reg, req_next;
    logic [COUNT_W-1:0] stop_reg, stop_next;
    logic [COUNT_W-1:0] first_reg, first_next;
    logic [COUNT_W-1:0] end_reg, end_next;
    logic [COUNT_W-1:0] idx_reg, idx_next;

    // Memory ports
    logic               a_re, a_we;
    logic [MA_W-1:0]    a_raddr, a_waddr;
    logic [COUNT_W-1:0] a_wdata;
    logic [COUNT_W-1:0] a_rdata_reg;
    logic               v_re, v_we;
    logic [VAR_W-1:0]   v_raddr, v_waddr;
    logic               v_wdata;
    logic               v_rdata_reg;

    logic               out_free;
    logic               in_fire;
    logic [COUNT_W-1:0] lvl_m1;
    logic [COUNT_W-1:0] tl_m1;
    logic [COUNT_W-1:0] end_val;
    logic [COUNT_W-1:0] idx_p1;
    logic               bad_var;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_free  = !out_valid_reg || out_ready;
    assign lvl_m1    = in_data.level - 7'd1;
    assign tl_m1     = tl_reg - 7'd1;
    assign idx_p1    = idx_reg + 7'd1;
    assign bad_var   = ({1'b0, in_data.var_index} >= NUM_VARS);

    // Sequencer and memory control
    always_comb
    begin
        state_next     = state_reg;
        dl_next        = dl_reg;
        tl_next        = tl_reg;
        vvalid_next    = vvalid_reg;
        rd_pend_next   = rd_pend_reg;
        more_next      = more_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        pend_next      = pend_reg;
        req_next       = req_reg;
        stop_next      = stop_reg;
        first_next     = first_reg;
        end_next       = end_reg;
        idx_next       = idx_reg;
        a_re           = 1'b0;
        a_raddr        = '0;
        a_we           = 1'b0;
        a_waddr        = '0;
        a_wdata        = '0;
        v_re           = 1'b0;
        v_raddr        = in_data.var_index;
        v_we           = 1'b0;
        v_waddr        = in_data.var_index;
        v_wdata        = in_data.positive;
        end_val        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    req_next       = in_data;
                    pend_next      = '0;
                    pend_next.last = 1'b1;
                    more_next      = 1'b0;
                    state_next     = S_RESP;
                    case (in_data.cmd)
                        CMD_ASSIGN:
                        begin
                            if (bad_var)
                                pend_next.status = ST_BAD_VAR;
                            else if (tl_reg >= NUM_VARS)
                                pend_next.status = ST_FULL;
                            else
                            begin
                                v_we    = 1'b1;
                                vvalid_next[in_data.var_index] = 1'b1;
                                a_we    = 1'b1;
                                a_waddr = {REGION_TRAIL, tl_reg[LVL_W-1:0]};
                                a_wdata = {in_data.var_index, in_data.positive};
                                tl_next = tl_reg + 7'd1;
                            end
                        end
                        CMD_NEW_LEVEL:
                        begin
                            if (dl_reg >= MAX_LEVELS)
                                pend_next.status = ST_FULL;
                            else
                            begin
                                a_we    = 1'b1;
                                a_waddr = {REGION_LEVEL, dl_reg[LVL_W-1:0]};
                                a_wdata = tl_reg;
                                dl_next = dl_reg + 7'd1;
                            end
                        end
                        CMD_BACKTRACK:
                        begin
                            if (in_data.level >= dl_reg)
                                pend_next.status = ST_BAD_LEVEL;
                            else
                            begin
                                a_re       = 1'b1;
                                a_raddr    = {REGION_LEVEL, in_data.level[LVL_W-1:0]};
                                state_next = S_BTLS;
                            end
                        end
                        CMD_QUERY:
                        begin
                            if (bad_var)
                                pend_next.status = ST_BAD_VAR;
                            else
                            begin
                                v_re       = 1'b1;
                                state_next = S_QRY;
                            end
                        end
                        CMD_LIST:
                        begin
                            if (in_data.level > dl_reg)
                                pend_next.status = ST_BAD_LEVEL;
                            else
                            begin
                                a_re       = 1'b1;
                                a_raddr    = {REGION_LEVEL, lvl_m1[LVL_W-1:0]};
                                state_next = S_LA;
                            end
                        end
                        default:
                        begin
                            pend_next.status = ST_OK;
                        end
                    endcase
                end
            end

            // Query answer; the polarity matches the literal means true
            S_QRY:
            begin
                if (!vvalid_reg[req_reg.var_index])
                    pend_next.lit_value = VAL_UNDEF;
                else if (v_rdata_reg == req_reg.positive)
                    pend_next.lit_value = VAL_TRUE;
                else
                    pend_next.lit_value = VAL_FALSE;
                state_next = S_RESP;
            end

            // Backtrack: take the level start, then walk the trail down
            S_BTLS:
            begin
                stop_next    = a_rdata_reg;
                rd_pend_next = 1'b0;
                state_next   = S_BTW;
            end

            S_BTW:
            begin
                if (rd_pend_reg)
                    vvalid_next[a_rdata_reg[COUNT_W-1:1]] = 1'b0;
                if (tl_reg > stop_reg)
                begin
                    a_re         = 1'b1;
                    a_raddr      = {REGION_TRAIL, tl_m1[LVL_W-1:0]};
                    tl_next      = tl_m1;
                    rd_pend_next = 1'b1;
                end
                else
                begin
                    rd_pend_next = 1'b0;
                    dl_next      = req_reg.level;
                    state_next   = S_RESP;
                end
            end

            // List: start of the level, then its end
            S_LA:
            begin
                first_next = (req_reg.level == '0) ? '0 : a_rdata_reg;
                a_re       = 1'b1;
                a_raddr    = {REGION_LEVEL, req_reg.level[LVL_W-1:0]};
                state_next = S_LB;
            end

            S_LB:
            begin
                end_val = (req_reg.level == dl_reg) ? tl_reg : a_rdata_reg;
                if (end_val > tl_reg)
                    end_val = tl_reg;
                if (first_reg >= end_val)
                    state_next = S_RESP;
                else
                begin
                    idx_next   = first_reg;
                    end_next   = end_val;
                    state_next = S_LRD;
                end
            end

            S_LRD:
            begin
                a_re       = 1'b1;
                a_raddr    = {REGION_TRAIL, idx_reg[LVL_W-1:0]};
                state_next = S_LOUT;
            end

            S_LOUT:
            begin
                pend_next                = '0;
                pend_next.trail_var      = a_rdata_reg[COUNT_W-1:1];
                pend_next.trail_positive = a_rdata_reg[0];
                pend_next.entry_valid    = 1'b1;
                pend_next.status         = ST_OK;
                pend_next.last           = (idx_p1 == end_reg);
                more_next                = (idx_p1 != end_reg);
                idx_next                 = idx_p1;
                state_next               = S_RESP;
            end

            // Hand the result to the output register
            S_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next              = 1'b1;
                    out_data_next               = pend_reg;
                    out_data_next.current_level = dl_reg;
                    out_data_next.trail_count   = tl_reg;
                    state_next                  = more_reg ? S_LRD : S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            dl_reg        <= '0;
            tl_reg        <= '0;
            vvalid_reg    <= '0;
            rd_pend_reg   <= 1'b0;
            more_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            dl_reg        <= dl_next;
            tl_reg        <= tl_next;
            vvalid_reg    <= vvalid_next;
            rd_pend_reg   <= rd_pend_next;
            more_reg      <= more_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        pend_reg     <= pend_next;
        req_reg      <= req_next;
        stop_reg     <= stop_next;
        first_reg    <= first_next;
        end_reg      <= end_next;
        idx_reg      <= idx_next;
    end

    // Trail / level-start memory
    always_ff @(posedge clk)
    begin
        if (a_we)
            tl_mem[a_waddr] <= a_wdata;
        if (a_re)
            a_rdata_reg <= tl_mem[a_raddr];
    end

    // Variable polarity memory
    always_ff @(posedge clk)
    begin
        if (v_we)
            pol_mem[v_waddr] <= v_wdata;
        if (v_re)
            v_rdata_reg <= pol_mem[v_raddr];
    end

    // Checks
    `SATT_ASSERT_IMP(a_tl_bound, 1'b1, tl_reg <= NUM_VARS, "trail length beyond capacity")
    `SATT_ASSERT_IMP(a_dl_bound, 1'b1, dl_reg <= MAX_LEVELS, "decision level beyond capacity")
    `SATT_ASSERT_IMP(a_walk_floor, state_reg == S_BTW, tl_reg >= stop_reg, "walk passed level start")
    `SATT_ASSERT_NXT(a_leave_idle, in_valid && in_ready, state_reg != S_IDLE, "accepted command lost")

endmodule
